// ----- sv/alias_table_weighted_sampler_assert.svh -----
// Assertion macros for the alias table weighted sampler.
// Depends on signals clk and rst_n being visible where a macro is used.
`ifndef ALIAS_TABLE_WEIGHTED_SAMPLER_ASSERT_SVH
`define ALIAS_TABLE_WEIGHTED_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define ATS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ats assertion failed");

// Next-cycle implication, checked out of reset
`define ATS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ats assertion failed");

`else

`define ATS_ASSERT_IMP(lbl, ante, cons)
`define ATS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- sv/ats_pkg.sv -----
// Shared types, constants and codes for the alias table weighted sampler.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package ats_pkg;

    // Table geometry and field widths
    localparam int unsigned SLOTS     = 65536;
    localparam int unsigned SLOT_W    = 16;
    localparam int unsigned CNT_W     = 17;
    localparam int unsigned THR_W     = 33;
    localparam int unsigned ID_W      = 32;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned U_SHIFT   = 11;
    localparam int unsigned U_W       = WORD_W - U_SHIFT;
    localparam int unsigned THR_SHIFT = 21;
    localparam int unsigned CMP_W     = THR_W + THR_SHIFT;
    localparam int unsigned DIV_CNT_W = $clog2(WORD_W + 1);

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    // Generator constants
    localparam logic [WORD_W-1:0] XS_MULT         = 64'd2685821657736338717;
    localparam logic [WORD_W-1:0] SEED_ZERO_SUBST = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] SEED_RESET      = 64'd1234567;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED         = 2'd1;

    // Request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // One table slot as stored in memory
    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [SLOT_W-1:0] alias_slot;
        logic [ID_W-1:0]   item_id;
    } ats_entry_t;

    // Table port command
    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] addr;
        ats_entry_t        wdata;
    } ats_tbl_cmd_t;

    // Generator control and status
    typedef struct packed {
        logic              load;
        logic [WORD_W-1:0] seed;
        logic              start;
    } ats_rng_ctl_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] word;
    } ats_rng_sts_t;

    // Divider control and status
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } ats_div_ctl_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] remainder;
    } ats_div_sts_t;

    // Generator multiply phases
    typedef enum logic [2:0] {
        RP_IDLE,
        RP_LO,
        RP_MID1,
        RP_MID2,
        RP_SUM
    } ats_rng_phase_t;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WORD1,
        S_WORD2,
        S_DIV,
        S_PRI,
        S_ALT,
        S_OUT
    } ats_state_t;

endpackage

// ----- sv/ats_if.sv -----
// Request and result channel interfaces for the alias table weighted sampler.
// Depends on ats_pkg for field widths.
interface ats_req_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [ats_pkg::SLOT_W-1:0]      slot;
    logic [ats_pkg::THR_W-1:0]       threshold;
    logic [ats_pkg::SLOT_W-1:0]      alias_slot;
    logic [ats_pkg::ID_W-1:0]        item_id;

    modport source (
        output valid, kind, slot, threshold, alias_slot, item_id,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, threshold, alias_slot, item_id,
        output ready
    );
endinterface

interface ats_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ats_pkg::ID_W-1:0]   sampled_id;
    logic                       took_alias;

    modport source (
        output valid, sampled_id, took_alias,
        input  ready
    );
    modport sink (
        input  valid, sampled_id, took_alias,
        output ready
    );
endinterface

// ----- sv/ats_tbl.sv -----
// Slot table memory: threshold, alias slot and item id in one word per slot.
// Depends on ats_pkg; one port, registered read data.
module ats_tbl (
    input  logic                  clk,
    input  ats_pkg::ats_tbl_cmd_t cmd,
    output ats_pkg::ats_entry_t   rdata
);

    ats_pkg::ats_entry_t mem_array [ats_pkg::SLOTS];
    ats_pkg::ats_entry_t rdata_reg;

    // Write on command, read the addressed slot every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem_array[cmd.addr] <= cmd.wdata;
        end
        rdata_reg <= mem_array[cmd.addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ats_rng.sv -----
// xorshift64* generator with the 64-bit product built on one 32x32 multiplier.
// Depends on ats_pkg; a word is ready, with done, after the multiply phases that follow start.
module ats_rng (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ats_pkg::ats_rng_ctl_t ctl,
    output ats_pkg::ats_rng_sts_t sts
);

    ats_pkg::ats_rng_phase_t         phase_reg, phase_next;
    logic [ats_pkg::WORD_W-1:0]      gen_reg, gen_next;
    logic [ats_pkg::WORD_W-1:0]      a_reg, a_next;
    logic [ats_pkg::WORD_W-1:0]      p0_reg, p0_next;
    logic [ats_pkg::HALF_W-1:0]      cross_reg, cross_next;
    logic [ats_pkg::WORD_W-1:0]      word_reg, word_next;
    logic                            done_reg, done_next;
    logic [ats_pkg::HALF_W-1:0]      mul_a, mul_b;
    logic [ats_pkg::WORD_W-1:0]      product;

    function automatic logic [ats_pkg::WORD_W-1:0] xorshift(
        input logic [ats_pkg::WORD_W-1:0] x
    );
        logic [ats_pkg::WORD_W-1:0] t;
        t = x ^ (x >> 12);
        t = t ^ (t << 25);
        t = t ^ (t >> 27);
        return t;
    endfunction

    // Shared multiplier
    assign product = mul_a * mul_b;

    // Control state and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ats_pkg::RP_IDLE;
            gen_reg   <= ats_pkg::SEED_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            gen_reg   <= gen_next;
            done_reg  <= done_next;
        end
    end

    // Partial products and result
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        p0_reg    <= p0_next;
        cross_reg <= cross_next;
        word_reg  <= word_next;
    end

    // Step the generator, then build the low product word through the LO, MID1, MID2 and SUM phases
    always_comb
    begin
        phase_next = phase_reg;
        gen_next   = gen_reg;
        a_next     = a_reg;
        p0_next    = p0_reg;
        cross_next = cross_reg;
        word_next  = word_reg;
        done_next  = 1'b0;
        mul_a      = a_reg[ats_pkg::HALF_W-1:0];
        mul_b      = ats_pkg::XS_MULT[ats_pkg::HALF_W-1:0];
        unique case (phase_reg)
            ats_pkg::RP_IDLE:
            begin
                if (ctl.load)
                begin
                    gen_next = (ctl.seed == '0) ? ats_pkg::SEED_ZERO_SUBST : ctl.seed;
                end
                else if (ctl.start)
                begin
                    gen_next   = xorshift(gen_reg);
                    a_next     = gen_next;
                    phase_next = ats_pkg::RP_LO;
                end
            end
            ats_pkg::RP_LO:
            begin
                p0_next    = product;
                phase_next = ats_pkg::RP_MID1;
            end
            ats_pkg::RP_MID1:
            begin
                mul_a      = a_reg[ats_pkg::WORD_W-1:ats_pkg::HALF_W];
                cross_next = product[ats_pkg::HALF_W-1:0];
                phase_next = ats_pkg::RP_MID2;
            end
            ats_pkg::RP_MID2:
            begin
                mul_b      = ats_pkg::XS_MULT[ats_pkg::WORD_W-1:ats_pkg::HALF_W];
                cross_next = cross_reg + product[ats_pkg::HALF_W-1:0];
                phase_next = ats_pkg::RP_SUM;
            end
            ats_pkg::RP_SUM:
            begin
                word_next  = p0_reg + {cross_reg, {ats_pkg::HALF_W{1'b0}}};
                done_next  = 1'b1;
                phase_next = ats_pkg::RP_IDLE;
            end
            default:
            begin
                phase_next = ats_pkg::RP_IDLE;
            end
        endcase
    end

    assign sts.done = done_reg;
    assign sts.word = word_reg;

endmodule

// ----- sv/ats_div.sv -----
// Restoring divider that returns the 64-bit dividend modulo a 17-bit divisor.
// Depends on ats_pkg and the assertion header; one quotient bit per cycle.
`include "alias_table_weighted_sampler_assert.svh"

module ats_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ats_pkg::ats_div_ctl_t ctl,
    output ats_pkg::ats_div_sts_t sts
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [ats_pkg::DIV_CNT_W-1:0]     count_reg, count_next;
    logic [ats_pkg::WORD_W-1:0]        dvd_reg, dvd_next;
    logic [ats_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [ats_pkg::CNT_W-1:0]         divisor_reg, divisor_next;
    logic [ats_pkg::CNT_W:0]           trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    // Load on start; while busy, shift in one dividend bit, subtract the divisor when it fits
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        trial        = {rem_reg, dvd_reg[ats_pkg::WORD_W-1]};
        if (ctl.start)
        begin
            busy_next    = 1'b1;
            count_next   = ats_pkg::DIV_CNT_W'(ats_pkg::WORD_W);
            dvd_next     = ctl.dividend;
            rem_next     = '0;
            divisor_next = ctl.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[ats_pkg::WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = ats_pkg::CNT_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = trial[ats_pkg::CNT_W-1:0];
            end
            count_next = count_reg - 1'b1;
            if (count_reg == ats_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign sts.done      = done_reg;
    assign sts.remainder = rem_reg[ats_pkg::SLOT_W-1:0];

    `ATS_ASSERT_IMP(a_rem_below_divisor, done_reg, rem_reg < divisor_reg)
    `ATS_ASSERT_IMP(a_no_restart, busy_reg, !ctl.start)
    `ATS_ASSERT_IMP(a_busy_counts, busy_reg, count_reg != '0)

endmodule

// ----- sv/alias_table_weighted_sampler.sv -----
// Top level of the alias table weighted sampler: sequencer, registers, output stage.
// Depends on ats_pkg, ats_if, ats_tbl, ats_rng, ats_div and the assertion header.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------------
//  req     | in  | valid / ready     | kind, slot, threshold, alias_slot, item_id
//  rsp     | out | valid / ready     | sampled_id, took_alias
//  cfg     | in  | cfg_we            | cfg_index, cfg_wdata
//
// A load request writes its slot while the sampler is idle. A draw request steps the
// generator for two words; the 64-step restoring divider reduces the first word modulo
// the active count while the second is built, then the primary slot is read, the alias
// slot too when the primary is not kept, and the result goes to the output stage.
// Reset clears control state only; table slots read undefined until loaded.
// A finished result waits in the output register; a new request is taken while
// it waits, and a second draw holds in its last state until the register frees.
`include "alias_table_weighted_sampler_assert.svh"

module alias_table_weighted_sampler (
    input  logic                              clk,
    input  logic                              rst_n,
    ats_req_if.sink                           req,
    ats_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [ats_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ats_pkg::WORD_W-1:0]        cfg_wdata
);

    ats_pkg::ats_state_t             state_reg, state_next;
    logic [ats_pkg::CNT_W-1:0]       active_count_reg, active_count_next;
    logic [ats_pkg::SLOT_W-1:0]      idx_reg, idx_next;
    logic [ats_pkg::U_W-1:0]         u_reg, u_next;
    logic [ats_pkg::ID_W-1:0]        res_id_reg, res_id_next;
    logic                            res_alias_reg, res_alias_next;
    logic                            out_valid_reg, out_valid_next;
    logic [ats_pkg::ID_W-1:0]        out_id_reg, out_id_next;
    logic                            out_alias_reg, out_alias_next;

    ats_pkg::ats_tbl_cmd_t           tbl_cmd;
    ats_pkg::ats_entry_t             tbl_rdata;
    ats_pkg::ats_rng_ctl_t           rng_ctl;
    ats_pkg::ats_rng_sts_t           rng_sts;
    ats_pkg::ats_div_ctl_t           div_ctl;
    ats_pkg::ats_div_sts_t           div_sts;

    logic                            req_fire;
    logic                            slot_ok;
    logic                            alias_ok;
    logic                            keep;
    logic                            seed_load;
    logic [ats_pkg::CNT_W-1:0]       n_eff;

    ats_tbl u_tbl (
        .clk   (clk),
        .cmd   (tbl_cmd),
        .rdata (tbl_rdata)
    );

    ats_rng u_rng (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rng_ctl),
        .sts   (rng_sts)
    );

    ats_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts)
    );

    assign req.ready     = (state_reg == ats_pkg::S_IDLE);
    assign req_fire      = req.valid & req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.sampled_id = out_id_reg;
    assign rsp.took_alias = out_alias_reg;

    assign slot_ok  = {1'b0, req.slot} < ats_pkg::SLOTS_CNT;
    assign alias_ok = {1'b0, tbl_rdata.alias_slot} < ats_pkg::SLOTS_CNT;
    assign keep     = {1'b0, u_reg} < {tbl_rdata.threshold, {ats_pkg::THR_SHIFT{1'b0}}};

    // Clamp the active count to one slot at least and the table size at most
    always_comb
    begin
        if (active_count_reg == '0)
        begin
            n_eff = ats_pkg::ONE_CNT;
        end
        else if (active_count_reg > ats_pkg::SLOTS_CNT)
        begin
            n_eff = ats_pkg::SLOTS_CNT;
        end
        else
        begin
            n_eff = active_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ats_pkg::S_IDLE;
            active_count_reg <= ats_pkg::ONE_CNT;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_count_reg <= active_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        u_reg         <= u_next;
        res_id_reg    <= res_id_next;
        res_alias_reg <= res_alias_next;
        out_id_reg    <= out_id_next;
        out_alias_reg <= out_alias_next;
    end

    // Decode configuration writes
    always_comb
    begin
        active_count_next = active_count_reg;
        seed_load         = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ats_pkg::CFG_ACTIVE_COUNT:
                begin
                    active_count_next = cfg_wdata[ats_pkg::CNT_W-1:0];
                end
                ats_pkg::CFG_SEED:
                begin
                    seed_load = 1'b1;
                end
                default:
                begin
                    active_count_next = active_count_reg;
                end
            endcase
        end
    end

    // Sequence one request: load, or two words, modulo, table reads, result
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        u_next           = u_reg;
        res_id_next      = res_id_reg;
        res_alias_next   = res_alias_reg;
        out_valid_next   = out_valid_reg & ~rsp.ready;
        out_id_next      = out_id_reg;
        out_alias_next   = out_alias_reg;

        tbl_cmd.wr                   = 1'b0;
        tbl_cmd.addr                 = req.slot;
        tbl_cmd.wdata.threshold      = req.threshold;
        tbl_cmd.wdata.alias_slot     = req.alias_slot;
        tbl_cmd.wdata.item_id        = req.item_id;

        rng_ctl.load     = seed_load;
        rng_ctl.seed     = cfg_wdata;
        rng_ctl.start    = 1'b0;
        div_ctl.start    = 1'b0;
        div_ctl.dividend = rng_sts.word;
        div_ctl.divisor  = n_eff;

        unique case (state_reg)
            ats_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.kind == ats_pkg::KIND_DRAW)
                    begin
                        rng_ctl.start = 1'b1;
                        state_next    = ats_pkg::S_WORD1;
                    end
                    else
                    begin
                        tbl_cmd.wr = slot_ok;
                    end
                end
            end
            ats_pkg::S_WORD1:
            begin
                // Start the modulo on the first word and draw the second
                if (rng_sts.done)
                begin
                    div_ctl.start = 1'b1;
                    rng_ctl.start = 1'b1;
                    state_next    = ats_pkg::S_WORD2;
                end
            end
            ats_pkg::S_WORD2:
            begin
                if (rng_sts.done)
                begin
                    u_next     = rng_sts.word[ats_pkg::WORD_W-1:ats_pkg::U_SHIFT];
                    state_next = ats_pkg::S_DIV;
                end
            end
            ats_pkg::S_DIV:
            begin
                // Read the primary slot as soon as its index is known
                tbl_cmd.addr = div_sts.remainder;
                if (div_sts.done)
                begin
                    idx_next   = div_sts.remainder;
                    state_next = ats_pkg::S_PRI;
                end
            end
            ats_pkg::S_PRI:
            begin
                if (keep)
                begin
                    res_id_next    = tbl_rdata.item_id;
                    res_alias_next = 1'b0;
                    state_next     = ats_pkg::S_OUT;
                end
                else
                begin
                    res_alias_next = 1'b1;
                    tbl_cmd.addr   = alias_ok ? tbl_rdata.alias_slot : idx_reg;
                    state_next     = ats_pkg::S_ALT;
                end
            end
            ats_pkg::S_ALT:
            begin
                res_id_next = tbl_rdata.item_id;
                state_next  = ats_pkg::S_OUT;
            end
            ats_pkg::S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_alias_next = res_alias_reg;
                    state_next     = ats_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ats_pkg::S_IDLE;
            end
        endcase
    end

    `ATS_ASSERT_IMP(a_div_done_in_div, div_sts.done, state_reg == ats_pkg::S_DIV)
    `ATS_ASSERT_IMP(a_rng_done_in_word, rng_sts.done, (state_reg == ats_pkg::S_WORD1) || (state_reg == ats_pkg::S_WORD2))
    `ATS_ASSERT_IMP(a_write_only_idle, tbl_cmd.wr, state_reg == ats_pkg::S_IDLE)
    `ATS_ASSERT_NXT(a_out_holds, (state_reg == ats_pkg::S_OUT) && out_valid_reg && !rsp.ready, state_reg == ats_pkg::S_OUT)

endmodule
